>>> hdl/arw_pkg.sv
`default_nettype none

package arw_pkg;

  // Window geometry. Both sizes are powers of two, so the ring word and bit
  // positions are plain bit fields of the counter.
  localparam int unsigned WINDOW_WORDS = 32;
  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned WIDX_W       = $clog2(WINDOW_WORDS);
  localparam int unsigned BIT_W        = $clog2(WORD_BITS);
  localparam int unsigned CNT_W        = 64;

  // Usable window in counters: one word less than the ring.
  localparam logic [CNT_W-1:0] WIN_SPAN = CNT_W'((WINDOW_WORDS - 1) * WORD_BITS);

  // Transaction modes.
  localparam logic [1:0] MODE_CHECK  = 2'd0;
  localparam logic [1:0] MODE_RECORD = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    VERDICT_FRESH = 2'd0,
    VERDICT_SEEN  = 2'd1,
    VERDICT_OLD   = 2'd2,
    VERDICT_ZERO  = 2'd3
  } verdict_e;

  // Comparison results of a counter against the highest recorded counter.
  typedef struct packed {
    logic              is_zero;
    logic              newer;
    logic              too_old;
    logic              clr_all;
    logic [WIDX_W-1:0] word_diff;
  } arw_flags_t;

  // Bitmap write port, including the range clear of an advancing window.
  typedef struct packed {
    logic                    en;
    logic [WIDX_W-1:0]       idx;
    logic [WORD_BITS-1:0]    data;
    logic                    clr_all;
    logic [WINDOW_WORDS-1:0] clr_mask;
  } arw_wr_t;

endpackage

`default_nettype wire

>>> hdl/arw_judge.sv
`default_nettype none

module arw_judge (
  input  wire logic                        clk_i,
  input  wire logic                        load_i,
  input  wire logic [arw_pkg::CNT_W-1:0]   counter_i,
  input  wire logic [arw_pkg::CNT_W-1:0]   highest_i,
  output arw_pkg::arw_flags_t              flags_o
);

  localparam int unsigned WNUM_W = arw_pkg::CNT_W - arw_pkg::BIT_W;

  arw_pkg::arw_flags_t flags_d;
  arw_pkg::arw_flags_t flags_q;
  logic [arw_pkg::CNT_W-1:0] age;
  logic [WNUM_W-1:0]         wdiff;

  // Age against the highest counter and distance in whole words.
  always_comb begin
    age   = highest_i - counter_i;
    wdiff = counter_i[arw_pkg::CNT_W-1:arw_pkg::BIT_W]
          - highest_i[arw_pkg::CNT_W-1:arw_pkg::BIT_W];
    flags_d.is_zero   = (counter_i == '0);
    flags_d.newer     = (counter_i > highest_i);
    flags_d.too_old   = (age > arw_pkg::WIN_SPAN);
    flags_d.clr_all   = (wdiff >= WNUM_W'(arw_pkg::WINDOW_WORDS));
    flags_d.word_diff = wdiff[arw_pkg::WIDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_q;

endmodule

`default_nettype wire

>>> hdl/arw_bitmap_mem.sv
`default_nettype none

module arw_bitmap_mem (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              rd_en_i,
  input  wire logic [arw_pkg::WIDX_W-1:0]        rd_idx_i,
  output logic      [arw_pkg::WORD_BITS-1:0]     rd_data_o,
  input  wire arw_pkg::arw_wr_t                  wr_i
);

  logic [arw_pkg::WORD_BITS-1:0]    mem [arw_pkg::WINDOW_WORDS];
  logic [arw_pkg::WINDOW_WORDS-1:0] valid_q;
  logic [arw_pkg::WINDOW_WORDS-1:0] valid_d;
  logic [arw_pkg::WINDOW_WORDS-1:0] set_mask;
  logic [arw_pkg::WORD_BITS-1:0]    rd_data_q;

  // Word storage; a word whose valid bit is low reads as zero.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_idx_i] ? mem[rd_idx_i] : '0;
    end
  end

  // Valid bits: range clears first, then the written word becomes valid.
  always_comb begin
    set_mask = '0;
    set_mask[wr_i.idx] = wr_i.en;
    if (wr_i.clr_all) begin
      valid_d = set_mask;
    end else begin
      valid_d = (valid_q & ~wr_i.clr_mask) | set_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> hdl/anti_replay_window.sv
// Channel | Handshake                       | Payload
// input   | in_valid_i / in_ready_o         | mode_i, counter_i
// output  | out_valid_o / out_ready_i       | verdict_o, highest_counter_o
//
// Each transaction runs in order: bitmap word read at acceptance, counter
// compares while the read data settles, then verdict and write-back.
// The bitmap memory read-modify-write sets this sequence.
// Reset clears the per-word valid bits at once; no clearing pass is needed.
// The write-back cycle waits while the output register holds an untaken result.
`default_nettype none

module anti_replay_window (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      mode_i,
  input  wire logic [arw_pkg::CNT_W-1:0]       counter_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [1:0]                      verdict_o,
  output logic      [arw_pkg::CNT_W-1:0]       highest_counter_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] verdict_q;
  logic [arw_pkg::CNT_W-1:0] out_hc_q;
  logic [arw_pkg::CNT_W-1:0] highest_seen_q, highest_seen_d;
  logic [1:0] mode_q;
  logic [arw_pkg::CNT_W-1:0] counter_q;

  logic in_fire;
  logic out_free;
  logic exec_fire;
  logic record_en;

  arw_pkg::verdict_e   verdict_d;
  arw_pkg::arw_flags_t flags;
  arw_pkg::arw_wr_t    wr;
  logic [arw_pkg::WORD_BITS-1:0] rd_data;
  logic [arw_pkg::WORD_BITS-1:0] base_word;
  logic [arw_pkg::WORD_BITS-1:0] bit_mask;
  logic [arw_pkg::WIDX_W-1:0]    start_idx;
  logic [arw_pkg::WIDX_W-1:0]    offset;
  logic [arw_pkg::BIT_W-1:0]     bit_idx;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign exec_fire  = (state_q == ST_EXEC) && out_free;

  // Bitmap memory: read at acceptance, written in the execute cycle.
  arw_bitmap_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_idx_i  (counter_i[arw_pkg::BIT_W +: arw_pkg::WIDX_W]),
    .rd_data_o (rd_data),
    .wr_i      (wr)
  );

  // Counter compares against the highest recorded counter.
  arw_judge u_judge (
    .clk_i     (clk_i),
    .load_i    (state_q == ST_CMP),
    .counter_i (counter_q),
    .highest_i (highest_seen_q),
    .flags_o   (flags)
  );

  // Capture the transaction payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q    <= mode_i;
      counter_q <= counter_i;
    end
  end

  // Verdict, window advance and the updated bitmap word.
  always_comb begin
    bit_idx   = counter_q[arw_pkg::BIT_W-1:0];
    start_idx = highest_seen_q[arw_pkg::BIT_W +: arw_pkg::WIDX_W];

    priority if (mode_q == arw_pkg::MODE_CLEAR) begin
      verdict_d = arw_pkg::VERDICT_FRESH;
    end else if (flags.is_zero) begin
      verdict_d = arw_pkg::VERDICT_ZERO;
    end else if (flags.newer) begin
      verdict_d = arw_pkg::VERDICT_FRESH;
    end else if (flags.too_old) begin
      verdict_d = arw_pkg::VERDICT_OLD;
    end else if (rd_data[bit_idx]) begin
      verdict_d = arw_pkg::VERDICT_SEEN;
    end else begin
      verdict_d = arw_pkg::VERDICT_FRESH;
    end

    record_en = (mode_q == arw_pkg::MODE_RECORD) && (verdict_d == arw_pkg::VERDICT_FRESH);

    // A newer counter in a later word lands in a word that is being zeroed.
    if (flags.newer && (flags.clr_all || (flags.word_diff != '0))) begin
      base_word = '0;
    end else begin
      base_word = rd_data;
    end
    bit_mask = '0;
    bit_mask[bit_idx] = 1'b1;

    wr.en       = exec_fire && record_en;
    wr.idx      = counter_q[arw_pkg::BIT_W +: arw_pkg::WIDX_W];
    wr.data     = base_word | bit_mask;
    wr.clr_all  = exec_fire && ((mode_q == arw_pkg::MODE_CLEAR)
                  || (record_en && flags.newer && flags.clr_all));
    wr.clr_mask = '0;
    // Words after the old highest word, up to the new highest word.
    for (int unsigned i = 0; i < arw_pkg::WINDOW_WORDS; i++) begin
      offset = arw_pkg::WIDX_W'(i) - start_idx - arw_pkg::WIDX_W'(1);
      wr.clr_mask[i] = exec_fire && record_en && flags.newer && (offset < flags.word_diff);
    end

    priority if (mode_q == arw_pkg::MODE_CLEAR) begin
      highest_seen_d = '0;
    end else if (record_en && flags.newer) begin
      highest_seen_d = counter_q;
    end else begin
      highest_seen_d = highest_seen_q;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      out_valid_q    <= 1'b0;
      highest_seen_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (exec_fire) begin
        highest_seen_q <= highest_seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      verdict_q <= verdict_d;
      out_hc_q  <= highest_seen_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign verdict_o         = verdict_q;
  assign highest_counter_o = out_hc_q;

  // The highest counter only grows, except on a window clear.
  a_highest_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && (mode_q != arw_pkg::MODE_CLEAR)
    |=> highest_seen_q >= $past(highest_seen_q))
    else $error("highest counter decreased without a clear");

  // A rejected counter leaves the window position unchanged.
  a_reject_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && (verdict_d != arw_pkg::VERDICT_FRESH)
    |=> $stable(highest_seen_q))
    else $error("rejected counter moved the window");

  // A pending result always reports the current window position.
  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_hc_q == highest_seen_q))
    else $error("pending result disagrees with highest counter");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
`default_nettype none

module tb;

  // Mode 3 is not defined; the block treats it as a check.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PROBES = 26;
  localparam logic [arw_pkg::CNT_W-1:0] CNT_MAX = '1;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [1:0]                mode_i = arw_pkg::MODE_CHECK;
  logic [arw_pkg::CNT_W-1:0] counter_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [1:0]                verdict_o;
  logic [arw_pkg::CNT_W-1:0] highest_counter_o;

  anti_replay_window dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .counter_i         (counter_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .verdict_o         (verdict_o),
    .highest_counter_o (highest_counter_o)
  );

  // One result as the window should report it.
  typedef struct packed {
    arw_pkg::verdict_e         verdict;
    logic [arw_pkg::CNT_W-1:0] highest;
  } window_result_t;

  // One directed row; typed rows carry their expected result.
  typedef struct packed {
    logic [1:0]                mode;
    logic [arw_pkg::CNT_W-1:0] counter;
    logic                      typed;
    arw_pkg::verdict_e         verdict;
    logic [arw_pkg::CNT_W-1:0] highest;
  } probe_t;

  probe_t probe_table [PROBES] = '{
    '{arw_pkg::MODE_CHECK,  64'd0,    1'b1, arw_pkg::VERDICT_ZERO,  64'd0},
    '{arw_pkg::MODE_RECORD, 64'd0,    1'b1, arw_pkg::VERDICT_ZERO,  64'd0},
    '{arw_pkg::MODE_CHECK,  64'd5,    1'b1, arw_pkg::VERDICT_FRESH, 64'd0},
    '{arw_pkg::MODE_RECORD, 64'd5,    1'b1, arw_pkg::VERDICT_FRESH, 64'd5},
    '{arw_pkg::MODE_RECORD, 64'd5,    1'b1, arw_pkg::VERDICT_SEEN,  64'd5},
    '{arw_pkg::MODE_CHECK,  64'd5,    1'b1, arw_pkg::VERDICT_SEEN,  64'd5},
    '{arw_pkg::MODE_RECORD, 64'd4,    1'b1, arw_pkg::VERDICT_FRESH, 64'd5},
    '{arw_pkg::MODE_RECORD, 64'd1000, 1'b1, arw_pkg::VERDICT_FRESH, 64'd1000},
    '{arw_pkg::MODE_CHECK,  64'd8,    1'b1, arw_pkg::VERDICT_FRESH, 64'd1000},
    '{arw_pkg::MODE_CHECK,  64'd7,    1'b1, arw_pkg::VERDICT_OLD,   64'd1000},
    '{arw_pkg::MODE_RECORD, 64'd7,    1'b1, arw_pkg::VERDICT_OLD,   64'd1000},
    '{MODE_SPARE,           64'd1000, 1'b1, arw_pkg::VERDICT_SEEN,  64'd1000},
    '{arw_pkg::MODE_RECORD, CNT_MAX,  1'b1, arw_pkg::VERDICT_FRESH, CNT_MAX},
    '{arw_pkg::MODE_CHECK,  64'd1000, 1'b1, arw_pkg::VERDICT_OLD,   CNT_MAX},
    '{arw_pkg::MODE_RECORD, 64'hFFFF_FFFF_FFFF_FC1F, 1'b1, arw_pkg::VERDICT_FRESH,
      CNT_MAX},
    '{arw_pkg::MODE_RECORD, 64'hFFFF_FFFF_FFFF_FC1E, 1'b1, arw_pkg::VERDICT_OLD,
      CNT_MAX},
    '{arw_pkg::MODE_RECORD, CNT_MAX,  1'b1, arw_pkg::VERDICT_SEEN,  CNT_MAX},
    '{arw_pkg::MODE_CLEAR,  CNT_MAX,  1'b1, arw_pkg::VERDICT_FRESH, 64'd0},
    '{arw_pkg::MODE_CHECK,  CNT_MAX,  1'b1, arw_pkg::VERDICT_FRESH, 64'd0},
    '{arw_pkg::MODE_RECORD, 64'd1,    1'b1, arw_pkg::VERDICT_FRESH, 64'd1},
    '{arw_pkg::MODE_RECORD, 64'h8000_0000_0000_0000, 1'b1, arw_pkg::VERDICT_FRESH,
      64'h8000_0000_0000_0000},
    '{arw_pkg::MODE_CHECK,  64'd1, 1'b1, arw_pkg::VERDICT_OLD, 64'h8000_0000_0000_0000},
    '{arw_pkg::MODE_RECORD, 64'h8000_0000_0000_0020, 1'b0, arw_pkg::VERDICT_FRESH,
      64'd0},
    '{arw_pkg::MODE_RECORD, 64'h7FFF_FFFF_FFFF_FC20, 1'b0, arw_pkg::VERDICT_FRESH,
      64'd0},
    '{arw_pkg::MODE_CHECK,  64'h8000_0000_0000_0020, 1'b0, arw_pkg::VERDICT_FRESH,
      64'd0},
    '{arw_pkg::MODE_CLEAR,  64'd0,    1'b1, arw_pkg::VERDICT_FRESH, 64'd0}
  };

  // Shadow copy of the window state.
  logic [arw_pkg::WORD_BITS-1:0] window_words [arw_pkg::WINDOW_WORDS];
  logic [arw_pkg::CNT_W-1:0]     window_top;

  window_result_t            pending_results [$];
  logic [arw_pkg::CNT_W-1:0] recent_counters [$];
  int                        fail_count = 0;
  int                        cycle_count = 0;
  int                        burst_left = 1;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Judge one transaction against the shadow window and record it if asked.
  task automatic judge_and_record(input logic [1:0] mode,
                                  input logic [arw_pkg::CNT_W-1:0] cnt,
                                  output window_result_t res);
    logic [arw_pkg::CNT_W-1:0]  cur_word;
    logic [arw_pkg::CNT_W-1:0]  word_gap;
    logic [arw_pkg::WIDX_W-1:0] slot;
    arw_pkg::verdict_e v;
    slot = cnt[arw_pkg::BIT_W +: arw_pkg::WIDX_W];
    if (mode == arw_pkg::MODE_CLEAR) begin
      for (int i = 0; i < arw_pkg::WINDOW_WORDS; i++) window_words[i] = '0;
      window_top = '0;
      v = arw_pkg::VERDICT_FRESH;
    end else begin
      if (cnt == '0) v = arw_pkg::VERDICT_ZERO;
      else if (cnt > window_top) v = arw_pkg::VERDICT_FRESH;
      else if (window_top - cnt > arw_pkg::WIN_SPAN) v = arw_pkg::VERDICT_OLD;
      else if (window_words[slot][cnt[arw_pkg::BIT_W-1:0]]) v = arw_pkg::VERDICT_SEEN;
      else v = arw_pkg::VERDICT_FRESH;
      if (mode == arw_pkg::MODE_RECORD && v == arw_pkg::VERDICT_FRESH) begin
        // Advancing the window zeroes the words it slides over.
        if (cnt > window_top) begin
          cur_word = window_top >> arw_pkg::BIT_W;
          word_gap = (cnt >> arw_pkg::BIT_W) - cur_word;
          if (word_gap > arw_pkg::CNT_W'(arw_pkg::WINDOW_WORDS))
            word_gap = arw_pkg::CNT_W'(arw_pkg::WINDOW_WORDS);
          for (int i = 0; i < int'(word_gap); i++)
            window_words[arw_pkg::WIDX_W'(cur_word + 1 + arw_pkg::CNT_W'(i))] = '0;
          window_top = cnt;
        end
        window_words[slot][cnt[arw_pkg::BIT_W-1:0]] = 1'b1;
      end
    end
    res.verdict = v;
    res.highest = window_top;
  endtask

  // Present one transaction, wait for acceptance, then pace the next burst.
  task automatic send_item(input logic [1:0] mode, input logic [arw_pkg::CNT_W-1:0] cnt,
                           input logic typed, input window_result_t typed_res);
    window_result_t res;
    int gap;
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    counter_i  <= cnt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    judge_and_record(mode, cnt, res);
    pending_results.push_back(typed ? typed_res : res);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Random transaction, mostly records that walk the window forward with
  // some backward, duplicate and out-of-window counters mixed in.
  task automatic pick_random(output logic [1:0] mode,
                             output logic [arw_pkg::CNT_W-1:0] cnt);
    int unsigned roll;
    int unsigned shape;
    roll  = $urandom_range(0, 99);
    shape = $urandom_range(0, 9);
    if (shape < 4)
      cnt = window_top + arw_pkg::CNT_W'($urandom_range(1, 40));
    else if (shape < 7)
      cnt = window_top - arw_pkg::CNT_W'($urandom_range(0, 1100));
    else if (shape < 9 && recent_counters.size() != 0)
      cnt = recent_counters[$urandom_range(0, recent_counters.size() - 1)];
    else
      cnt = window_top + arw_pkg::CNT_W'($urandom_range(41, 3000));
    mode = arw_pkg::MODE_RECORD;
    if (roll < 3) begin
      mode = arw_pkg::MODE_CLEAR;
      cnt  = {$urandom, $urandom};
    end else if (roll < 6) begin
      mode = MODE_SPARE;
    end else if (roll < 9) begin
      mode = roll[0] ? arw_pkg::MODE_RECORD : arw_pkg::MODE_CHECK;
      cnt  = '0;
    end else if (roll < 11) begin
      cnt = {$urandom, $urandom};
    end else if (roll < 13) begin
      cnt = CNT_MAX - arw_pkg::CNT_W'($urandom_range(0, 3000));
    end else if (roll < 30) begin
      mode = arw_pkg::MODE_CHECK;
    end
  endtask

  // Stimulus: directed rows, then random traffic, then drain.
  initial begin : stimulus
    logic [1:0] mode;
    logic [arw_pkg::CNT_W-1:0] cnt;
    window_result_t typed_res;
    for (int i = 0; i < arw_pkg::WINDOW_WORDS; i++) window_words[i] = '0;
    window_top = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PROBES; i++) begin
      typed_res.verdict = probe_table[i].verdict;
      typed_res.highest = probe_table[i].highest;
      send_item(probe_table[i].mode, probe_table[i].counter, probe_table[i].typed,
                typed_res);
    end

    typed_res = '0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick_random(mode, cnt);
      send_item(mode, cnt, 1'b0, typed_res);
      if (mode == arw_pkg::MODE_RECORD && cnt != '0) begin
        recent_counters.push_back(cnt);
        if (recent_counters.size() > 16) void'(recent_counters.pop_front());
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result consumer: open stretches, short bursts and stalls.
  initial begin : result_sink
    int hold;
    logic level;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      case ($urandom_range(0, 5))
        0: begin
          level = 1'b1;
          hold  = $urandom_range(20, 60);
        end
        1, 2, 3: begin
          level = 1'b1;
          hold  = $urandom_range(1, 6);
        end
        default: begin
          level = 1'b0;
          hold  = $urandom_range(1, 8);
        end
      endcase
      out_ready_i <= level;
      repeat (hold) @(posedge clk_i);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    window_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result verdict %0d highest %0h", $time, verdict_o,
                 highest_counter_o);
      end else begin
        exp_res = pending_results.pop_front();
        if (verdict_o !== exp_res.verdict) begin
          fail_count++;
          $display("%0t: verdict expected %0d actual %0d", $time, exp_res.verdict,
                   verdict_o);
        end
        if (highest_counter_o !== exp_res.highest) begin
          fail_count++;
          $display("%0t: highest counter expected %0h actual %0h", $time,
                   exp_res.highest, highest_counter_o);
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

`default_nettype wire
